FILE: design/dmwm_pkg.sv
// types and constants shared by the depth map weighted merge block
// no dependencies; every other file imports this package

package dmwm_pkg;

   // field widths of one pixel
   localparam int DEPTH_BITS = 16;
   localparam int COUNT_BITS = 8;
   localparam int PROD_BITS  = DEPTH_BITS + COUNT_BITS;

   // configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_VALID_DEPTH = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VALID_DEPTH = 4'd1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [DEPTH_BITS-1:0] stored_depth;
      logic [DEPTH_BITS-1:0] new_depth;
      logic [COUNT_BITS-1:0] count_in;
   } req_payload_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] merged_depth;
      logic [COUNT_BITS-1:0] count_out;
   } rsp_payload_type;

   // after range check and multiply
   typedef struct packed {
      logic [DEPTH_BITS-1:0] stored_depth;
      logic [DEPTH_BITS-1:0] new_depth;
      logic [COUNT_BITS-1:0] count_in;
      logic                  stored_ok;
      logic                  new_ok;
      logic [PROD_BITS-1:0]  product;
   } front_type;

   // one step of the restoring divider, with the fall-back result alongside
   typedef struct packed {
      logic                  both_ok;
      logic [DEPTH_BITS-1:0] alt_depth;
      logic [COUNT_BITS-1:0] count_out;
      logic [COUNT_BITS:0]   divisor;
      logic [COUNT_BITS-1:0] rem;
      logic [DEPTH_BITS-1:0] work;
   } div_type;

endpackage

FILE: design/dmwm_front.sv
// first pipeline stage: depth range check and stored depth times count
// depends on dmwm_pkg

module dmwm_front
   import dmwm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  req_payload_type       up_data,
   input  logic [DEPTH_BITS-1:0] min_depth,
   input  logic [DEPTH_BITS-1:0] max_depth,
   output logic                  down_valid,
   input  logic                  down_ready,
   output front_type             down_data
);

   logic      valid_ff;
   logic      valid_in;
   front_type data_ff;
   front_type data_in;

   // stage moves when empty or when the next stage takes its item
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // range test and product
   always_comb begin
      data_in.stored_depth = up_data.stored_depth;
      data_in.new_depth    = up_data.new_depth;
      data_in.count_in     = up_data.count_in;
      data_in.stored_ok    = (up_data.stored_depth >= min_depth)
                             && (up_data.stored_depth <= max_depth);
      data_in.new_ok       = (up_data.new_depth >= min_depth)
                             && (up_data.new_depth <= max_depth);
      data_in.product      = PROD_BITS'(up_data.stored_depth) * PROD_BITS'(up_data.count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

FILE: design/dmwm_prep.sv
// second pipeline stage: dividend, divisor, count update and single-depth result
// depends on dmwm_pkg

module dmwm_prep
   import dmwm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      up_valid,
   output logic      up_ready,
   input  front_type up_data,
   output logic      down_valid,
   input  logic      down_ready,
   output div_type   down_data
);

   logic                 valid_ff;
   logic                 valid_in;
   div_type              data_ff;
   div_type              data_in;
   logic [PROD_BITS-1:0] dividend;

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // the quotient always fits the depth width, so the top bits seed the remainder
   assign dividend = up_data.product + PROD_BITS'(up_data.new_depth);

   always_comb begin
      data_in.both_ok = up_data.stored_ok && up_data.new_ok;
      data_in.divisor = {1'b0, up_data.count_in} + (COUNT_BITS+1)'(1);
      data_in.rem     = dividend[PROD_BITS-1:DEPTH_BITS];
      data_in.work    = dividend[DEPTH_BITS-1:0];
      // result when at most one depth is in range
      if (up_data.stored_ok && !up_data.new_ok) begin
         data_in.alt_depth = up_data.stored_depth;
      end else if (!up_data.stored_ok && up_data.new_ok) begin
         data_in.alt_depth = up_data.new_depth;
      end else begin
         data_in.alt_depth = '0;
      end
      // count update, saturating
      if (up_data.stored_ok && up_data.new_ok) begin
         data_in.count_out = (up_data.count_in == COUNT_MAX) ? COUNT_MAX
                             : up_data.count_in + COUNT_BITS'(1);
      end else if (up_data.stored_ok || up_data.new_ok) begin
         data_in.count_out = COUNT_BITS'(1);
      end else begin
         data_in.count_out = up_data.count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

FILE: design/dmwm_div_step.sv
// one stage of the pipelined restoring divider: one quotient bit per stage
// depends on dmwm_pkg

module dmwm_div_step
   import dmwm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  div_type up_data,
   output logic    down_valid,
   input  logic    down_ready,
   output div_type down_data
);

   logic                valid_ff;
   logic                valid_in;
   div_type             data_ff;
   div_type             data_in;
   logic [COUNT_BITS:0] trial;
   logic [COUNT_BITS:0] diff;
   logic                fits;

   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // shift in the next dividend bit and try the subtract
   assign trial = {up_data.rem, up_data.work[DEPTH_BITS-1]};
   assign diff  = trial - up_data.divisor;
   assign fits  = trial >= up_data.divisor;

   always_comb begin
      data_in      = up_data;
      data_in.rem  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      data_in.work = {up_data.work[DEPTH_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

FILE: design/depth_map_weighted_merge_top.sv
// top level of the depth map weighted merge: range registers, pipeline, output register
// depends on dmwm_pkg, dmwm_front, dmwm_prep, dmwm_div_step

// Fuses two depth maps pixel by pixel as a running average weighted by the
// pixel's fusion count. One pixel is taken every cycle unless the output stalls;
// each result passes one stage for the range test and multiply, one to form
// dividend and divisor, 16 divider stages that each produce one quotient bit,
// and the output register. Every stage stalls only when it holds an item that
// the next one cannot take, so gaps close up under back-pressure. The valid
// depth range is to be written through the csr port only while no pixel is in
// flight; the block does not enforce this. Writes to unknown indexes are ignored.

module depth_map_weighted_merge_top
   import dmwm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [DEPTH_BITS-1:0]               min_depth_ff;
   logic [DEPTH_BITS-1:0]               max_depth_ff;
   logic [DEPTH_BITS+CSR_DATA_BITS-1:0] wdata_wide;
   logic [DEPTH_BITS+CSR_DATA_BITS-1:0] max_reset_wide;

   logic      front_valid;
   logic      front_ready;
   front_type front_data;

   logic    div_valid [0:DEPTH_BITS];
   logic    div_ready [0:DEPTH_BITS];
   div_type div_data  [0:DEPTH_BITS];

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            out_ready;

   // configuration registers
   assign csr_ready      = 1'b1;
   assign wdata_wide     = {{DEPTH_BITS{1'b0}}, csr_wdata};
   assign max_reset_wide = {{DEPTH_BITS{1'b0}}, {CSR_DATA_BITS{1'b1}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_depth_ff <= DEPTH_BITS'(1);
         max_depth_ff <= max_reset_wide[DEPTH_BITS-1:0];
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_VALID_DEPTH: begin
               min_depth_ff <= wdata_wide[DEPTH_BITS-1:0];
            end
            CSR_MAX_VALID_DEPTH: begin
               max_depth_ff <= wdata_wide[DEPTH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // range check and multiply
   dmwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_data    (req_payload),
      .min_depth  (min_depth_ff),
      .max_depth  (max_depth_ff),
      .down_valid (front_valid),
      .down_ready (front_ready),
      .down_data  (front_data)
   );

   // divider set-up
   dmwm_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (front_valid),
      .up_ready   (front_ready),
      .up_data    (front_data),
      .down_valid (div_valid[0]),
      .down_ready (div_ready[0]),
      .down_data  (div_data[0])
   );

   // divider chain
   for (genvar i = 0; i < DEPTH_BITS; i++) begin : g_div
      dmwm_div_step u_step (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (div_valid[i]),
         .up_ready   (div_ready[i]),
         .up_data    (div_data[i]),
         .down_valid (div_valid[i+1]),
         .down_ready (div_ready[i+1]),
         .down_data  (div_data[i+1])
      );
   end

   // output register with the final choice of result
   assign out_ready                = !rsp_valid_ff || rsp_ready;
   assign div_ready[DEPTH_BITS]    = out_ready;
   assign rsp_valid_in             = out_ready ? div_valid[DEPTH_BITS] : rsp_valid_ff;
   assign rsp_in.merged_depth      = div_data[DEPTH_BITS].both_ok ? div_data[DEPTH_BITS].work
                                     : div_data[DEPTH_BITS].alt_depth;
   assign rsp_in.count_out         = div_data[DEPTH_BITS].count_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid[DEPTH_BITS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a non-zero depth always comes with at least one observation
   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.merged_depth != '0) |-> rsp_ff.count_out != '0)
      else $error("merged depth without a counted observation");

   // divider remainder stays below the divisor
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      div_valid[DEPTH_BITS] |->
         ({1'b0, div_data[DEPTH_BITS].rem} < div_data[DEPTH_BITS].divisor))
      else $error("divider remainder not below divisor");

   // a stalled output keeps the last divider stage full
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      div_valid[DEPTH_BITS] && rsp_valid_ff && !rsp_ready |=> div_valid[DEPTH_BITS])
      else $error("item dropped from last divider stage under stall");

   // minimum range register takes the written value
   a_min_write : assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_MIN_VALID_DEPTH) |=>
         min_depth_ff == $past(wdata_wide[DEPTH_BITS-1:0]))
      else $error("minimum depth register not updated by write");

endmodule
